// ===== src/mdhl_pkg.sv =====
// ----------------------------------------------------------------------------
// mdhl_pkg
// types and command codes shared by the multiply/divide unit
// ----------------------------------------------------------------------------
package mdhl_pkg;

	typedef enum logic [2:0] {
		CMD_MULT  = 3'd0,
		CMD_MULTU = 3'd1,
		CMD_DIV   = 3'd2,
		CMD_DIVU  = 3'd3,
		CMD_MADD  = 3'd4,
		CMD_MADDU = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        pipe_sel;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [4:0]  dest_index;
	} in_item_t;

	typedef struct packed {
		logic        dest_write;
		logic [4:0]  dest_out;
		logic [63:0] dest_value;
		logic [63:0] lo_value;
		logic [63:0] hi_value;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_mul;
		logic        is_div;
		logic        is_acc;
		logic        sgn;
		logic        pipe_sel;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [4:0]  dest_index;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} state_t;

	localparam logic [31:0] INT_MIN32 = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

endpackage

// ===== src/mult_div_hilo_unit.sv =====
// ----------------------------------------------------------------------------
// mult_div_hilo_unit
// multiply/divide unit with two hi/lo register pairs
// ----------------------------------------------------------------------------
// in channel: in_valid / in_stall with in_item (command, pipe, operands, dest).
// out channel: out_valid / out_stall with out_item (write-back flag, dest,
// new lo and hi of the selected pipe). each item yields exactly one result.
// a two-entry queue decouples decode from execution, so items are taken while
// the execute side is busy or its result waits.
// the back end executes one item at a time: multiply, multiply-add, or divide with
// one quotient bit a cycle in the shared restoring divider, plus setup and sign fix.
// the divider loop sets the sustained rate.
// reset clears all hi/lo pairs to zero and empties the queue.
// when the receiver stalls, the result holds and the next item waits once executed;
// the queue keeps taking items until full. unused command codes change no hi/lo pair.
// ----------------------------------------------------------------------------
module mult_div_hilo_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mdhl_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mdhl_pkg::out_item_t out_item
);

	logic          op_valid, op_take;
	mdhl_pkg::op_t op;

	mdhl_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.op_valid, .op_take, .op
	);

	mdhl_back u_back (
		.clk, .arst_n, .op_valid, .op_take, .op,
		.out_valid, .out_stall, .out_item
	);

`ifndef ASSERT_OFF
	a_no_write_dest0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.dest_write && out_item.dest_out == 5'd0))
		else $error("write-back with zero destination");
	a_dest_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.dest_write |-> out_item.dest_value == out_item.lo_value)
		else $error("write-back value differs from lo");
	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |-> op_valid)
		else $error("back end took from empty queue");
`endif

endmodule

// ===== src/mdhl_front.sv =====
// ----------------------------------------------------------------------------
// mdhl_front
// accepts items, decodes the command and queues them for the back end
// ----------------------------------------------------------------------------
module mdhl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mdhl_pkg::in_item_t  in_item,
	output logic                op_valid,
	input  logic                op_take,
	output mdhl_pkg::op_t       op
);

	mdhl_pkg::op_t q_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	mdhl_pkg::op_t dec;
	logic          push, pop;

	always_comb begin
		dec            = '0;
		dec.pipe_sel   = in_item.pipe_sel;
		dec.operand_a  = in_item.operand_a;
		dec.operand_b  = in_item.operand_b;
		dec.dest_index = in_item.dest_index;
		case (in_item.cmd)
			mdhl_pkg::CMD_MULT: begin
				dec.is_mul = 1'b1; dec.sgn = 1'b1;
			end
			mdhl_pkg::CMD_MULTU: dec.is_mul = 1'b1;
			mdhl_pkg::CMD_DIV: begin
				dec.is_div = 1'b1; dec.sgn = 1'b1;
			end
			mdhl_pkg::CMD_DIVU: dec.is_div = 1'b1;
			mdhl_pkg::CMD_MADD: begin
				dec.is_mul = 1'b1; dec.is_acc = 1'b1; dec.sgn = 1'b1;
			end
			mdhl_pkg::CMD_MADDU: begin
				dec.is_mul = 1'b1; dec.is_acc = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_stall = cnt_q[1];
	assign push     = in_valid && !in_stall;
	assign op_valid = cnt_q != 2'd0;
	assign pop      = op_valid && op_take;
	assign op       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/mdhl_back.sv =====
// ----------------------------------------------------------------------------
// mdhl_back
// executes one queued item: multiply, multiply-add or bit-serial divide
// ----------------------------------------------------------------------------
module mdhl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	output logic                op_take,
	input  mdhl_pkg::op_t       op,
	output logic                out_valid,
	input  logic                out_stall,
	output mdhl_pkg::out_item_t out_item
);

	mdhl_pkg::state_t    st_q, st_d;
	mdhl_pkg::op_t       op_q;
	logic [63:0] lo_q [2];
	logic [63:0] hi_q [2];
	logic [63:0] prod_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        valid_q;
	logic [63:0] lo_new_q, hi_new_q;
	mdhl_pkg::out_item_t out_q;

	logic signed [32:0] xa, xb;
	logic signed [65:0] prod_full;
	logic [63:0] acc_lo, cur_lo, cur_hi, hi_ext, res_lo, res_hi;
	logic        carry, done, wr_d;
	logic [32:0] trial;
	logic [31:0] ma, mb, q_fix, r_fix;
	logic        a_neg, b_neg;

	assign cur_lo = lo_q[op_q.pipe_sel];
	assign cur_hi = hi_q[op_q.pipe_sel];
	// one extra bit carries the sign for signed commands
	assign xa        = {op_q.sgn & op_q.operand_a[31], op_q.operand_a};
	assign xb        = {op_q.sgn & op_q.operand_b[31], op_q.operand_b};
	assign prod_full = xa * xb;
	assign {carry, acc_lo} = {1'b0, cur_lo} + {1'b0, prod_q};
	assign hi_ext = cur_hi + ((op_q.sgn && prod_q[63]) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0)
	              + {63'd0, carry};
	assign a_neg  = op_q.sgn && op_q.operand_a[31];
	assign b_neg  = op_q.sgn && op_q.operand_b[31];
	assign ma     = a_neg ? 32'd0 - op_q.operand_a : op_q.operand_a;
	assign mb     = b_neg ? 32'd0 - op_q.operand_b : op_q.operand_b;
	// one restoring step: shift in next dividend bit
	assign trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign q_fix  = (a_neg != b_neg) ? 32'd0 - quo_q : quo_q;
	assign r_fix  = a_neg ? 32'd0 - rem_q : rem_q;

	assign res_lo = (op_q.is_mul && !op_q.is_acc) ? {{32{prod_q[31]}}, prod_q[31:0]}
	                                              : lo_new_q;
	assign res_hi = (op_q.is_mul && !op_q.is_acc) ? {{32{prod_q[63]}}, prod_q[63:32]}
	                                              : hi_new_q;
	assign wr_d   = (op_q.is_mul || op_q.is_div) && op_q.dest_index != 5'd0;
	assign done   = (st_q == mdhl_pkg::ST_OUT) && (st_d == mdhl_pkg::ST_IDLE);

	assign out_valid = valid_q;
	assign out_item  = out_q;

	always_comb begin
		st_d    = st_q;
		op_take = 1'b0;
		case (st_q)
			mdhl_pkg::ST_IDLE: begin
				if (op_valid) begin
					op_take = 1'b1;
					st_d    = mdhl_pkg::ST_MUL;
				end
			end
			mdhl_pkg::ST_MUL: begin
				if (op_q.is_div) st_d = mdhl_pkg::ST_DIV;
				else if (op_q.is_acc) st_d = mdhl_pkg::ST_ACC;
				else st_d = mdhl_pkg::ST_OUT;
			end
			mdhl_pkg::ST_ACC: st_d = mdhl_pkg::ST_OUT;
			mdhl_pkg::ST_DIV: if (cnt_q == 6'd31) st_d = mdhl_pkg::ST_FIX;
			mdhl_pkg::ST_FIX: st_d = mdhl_pkg::ST_OUT;
			mdhl_pkg::ST_OUT: if (!valid_q || !out_stall) st_d = mdhl_pkg::ST_IDLE;
			default: st_d = mdhl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= mdhl_pkg::ST_IDLE;
			valid_q <= 1'b0;
			lo_q    <= '{default: '0};
			hi_q    <= '{default: '0};
		end else begin
			st_q <= st_d;
			if (done) begin
				valid_q <= 1'b1;
				if (op_q.is_mul || op_q.is_div) begin
					lo_q[op_q.pipe_sel] <= res_lo;
					hi_q[op_q.pipe_sel] <= res_hi;
				end
			end else if (valid_q && !out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			mdhl_pkg::ST_IDLE: if (op_take) op_q <= op;
			mdhl_pkg::ST_MUL: begin
				prod_q   <= prod_full[63:0];
				lo_new_q <= cur_lo;
				hi_new_q <= cur_hi;
				rem_q    <= 32'd0;
				quo_q    <= ma;
				dvs_q    <= mb;
				cnt_q    <= 6'd0;
			end
			mdhl_pkg::ST_ACC: begin
				lo_new_q <= acc_lo;
				hi_new_q <= hi_ext;
			end
			mdhl_pkg::ST_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			mdhl_pkg::ST_FIX: begin
				if (op_q.operand_b == 32'd0) begin
					lo_new_q <= (op_q.sgn && op_q.operand_a[31]) ? 64'd1
					          : {32'hFFFF_FFFF, mdhl_pkg::ALL_ONES32};
					hi_new_q <= {{32{op_q.operand_a[31]}}, op_q.operand_a};
				end else begin
					lo_new_q <= {{32{q_fix[31]}}, q_fix};
					hi_new_q <= {{32{r_fix[31]}}, r_fix};
				end
			end
			mdhl_pkg::ST_OUT: begin
				// result register only loads once the previous item has left
				if (done) begin
					out_q.dest_write <= wr_d;
					out_q.dest_out   <= op_q.dest_index;
					out_q.dest_value <= wr_d ? res_lo : 64'd0;
					out_q.lo_value   <= res_lo;
					out_q.hi_value   <= res_hi;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives random and directed multiply/divide items into mult_div_hilo_unit and
// checks every result against a hi/lo pair predictor kept in a scoreboard
// ----------------------------------------------------------------------------
module testbench;

	class hilo_scoreboard;
		logic [63:0]         lo_pair [2];
		logic [63:0]         hi_pair [2];
		mdhl_pkg::out_item_t pending_q [$];
		int                  mismatches;

		function new();
			lo_pair[0] = '0; lo_pair[1] = '0;
			hi_pair[0] = '0; hi_pair[1] = '0;
			mismatches = 0;
		endfunction

		function logic [63:0] sext(logic [31:0] x);
			return {{32{x[31]}}, x};
		endfunction

		function void note_item(mdhl_pkg::in_item_t it);
			logic [63:0] lo, hi, prod, old;
			logic [31:0] q, r, ma, mb;
			logic        ok, an, bn;
			mdhl_pkg::out_item_t res;
			lo = lo_pair[it.pipe_sel];
			hi = hi_pair[it.pipe_sel];
			ok = 1'b1;
			an = it.operand_a[31];
			bn = it.operand_b[31];
			case (it.cmd)
				mdhl_pkg::CMD_MULT, mdhl_pkg::CMD_MULTU: begin
					prod = (it.cmd == mdhl_pkg::CMD_MULT)
						? sext(it.operand_a) * sext(it.operand_b)
						: {32'd0, it.operand_a} * {32'd0, it.operand_b};
					lo = sext(prod[31:0]);
					hi = sext(prod[63:32]);
				end
				mdhl_pkg::CMD_DIV: begin
					if (it.operand_b == 0) begin
						q = an ? 32'd1 : mdhl_pkg::ALL_ONES32;
						r = it.operand_a;
					end else begin
						ma = an ? -it.operand_a : it.operand_a;
						mb = bn ? -it.operand_b : it.operand_b;
						q = ma / mb;
						r = ma % mb;
						if (an != bn) q = -q;
						if (an) r = -r;
					end
					lo = sext(q);
					hi = sext(r);
				end
				mdhl_pkg::CMD_DIVU: begin
					if (it.operand_b == 0) begin
						q = mdhl_pkg::ALL_ONES32;
						r = it.operand_a;
					end else begin
						q = it.operand_a / it.operand_b;
						r = it.operand_a % it.operand_b;
					end
					lo = sext(q);
					hi = sext(r);
				end
				mdhl_pkg::CMD_MADD, mdhl_pkg::CMD_MADDU: begin
					old = lo;
					prod = (it.cmd == mdhl_pkg::CMD_MADD)
						? sext(it.operand_a) * sext(it.operand_b)
						: {32'd0, it.operand_a} * {32'd0, it.operand_b};
					lo = old + prod;
					if (it.cmd == mdhl_pkg::CMD_MADD && prod[63]) hi = hi - 64'd1;
					if (lo < old) hi = hi + 64'd1;
				end
				default: ok = 1'b0;
			endcase
			if (ok) begin
				lo_pair[it.pipe_sel] = lo;
				hi_pair[it.pipe_sel] = hi;
			end
			res.dest_write = ok && it.dest_index != 0;
			res.dest_out = it.dest_index;
			res.dest_value = res.dest_write ? lo : 64'd0;
			res.lo_value = lo;
			res.hi_value = hi;
			pending_q.push_back(res);
		endfunction

		function void check_result(mdhl_pkg::out_item_t got);
			mdhl_pkg::out_item_t exp;
			if (pending_q.size() == 0) begin
				report("unexpected result", 0, 0);
				return;
			end
			exp = pending_q.pop_front();
			if (got.dest_write !== exp.dest_write)
				report("dest_write", exp.dest_write, got.dest_write);
			if (got.dest_out !== exp.dest_out)
				report("dest_out", exp.dest_out, got.dest_out);
			if (got.dest_value !== exp.dest_value)
				report("dest_value", exp.dest_value, got.dest_value);
			if (got.lo_value !== exp.lo_value)
				report("lo_value", exp.lo_value, got.lo_value);
			if (got.hi_value !== exp.hi_value)
				report("hi_value", exp.hi_value, got.hi_value);
		endfunction

		function void report(string what, logic [63:0] exp, logic [63:0] got);
			mismatches++;
			if (mismatches <= 50)
				$display("mismatch %s: expected %h got %h", what, exp, got);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	mdhl_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	mdhl_pkg::out_item_t out_item;

	hilo_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	mult_div_hilo_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// send one item, waiting out stall; valid stays up for a back-to-back item
	task automatic send_item(mdhl_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return mdhl_pkg::ALL_ONES32;
			2: return mdhl_pkg::INT_MIN32;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_fields(logic [2:0] c, logic p, logic [31:0] a, logic [31:0] b,
			logic [4:0] d);
		mdhl_pkg::in_item_t it;
		it.cmd = c; it.pipe_sel = p; it.operand_a = a; it.operand_b = b;
		it.dest_index = d;
		send_item(it);
	endtask

	// receiver: stall at random, or hold off for a long stretch
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b1;
		else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);
	end

	initial begin
		int phase, n, waited;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, divide corner cases, unused codes
		send_fields(mdhl_pkg::CMD_MULT, 0, mdhl_pkg::INT_MIN32, mdhl_pkg::INT_MIN32, 5'd1);
		send_fields(mdhl_pkg::CMD_MULTU, 1, mdhl_pkg::ALL_ONES32, mdhl_pkg::ALL_ONES32,
			5'd31);
		send_fields(mdhl_pkg::CMD_MULT, 0, mdhl_pkg::ALL_ONES32, 32'd1, 5'd0);
		send_fields(mdhl_pkg::CMD_DIV, 0, 32'd7, 32'd0, 5'd2);
		send_fields(mdhl_pkg::CMD_DIV, 1, 32'hFFFF_FFF9, 32'd0, 5'd3);
		send_fields(mdhl_pkg::CMD_DIVU, 0, 32'd9, 32'd0, 5'd4);
		send_fields(mdhl_pkg::CMD_DIV, 1, mdhl_pkg::INT_MIN32, mdhl_pkg::ALL_ONES32, 5'd5);
		send_fields(mdhl_pkg::CMD_DIV, 0, 32'hFFFF_FFF9, 32'd2, 5'd6);
		send_fields(mdhl_pkg::CMD_DIV, 1, 32'd7, 32'hFFFF_FFFE, 5'd7);
		send_fields(mdhl_pkg::CMD_DIVU, 1, mdhl_pkg::ALL_ONES32, 32'd3, 5'd8);
		send_fields(mdhl_pkg::CMD_MADDU, 0, mdhl_pkg::ALL_ONES32, mdhl_pkg::ALL_ONES32,
			5'd9);
		send_fields(mdhl_pkg::CMD_MADDU, 0, mdhl_pkg::ALL_ONES32, mdhl_pkg::ALL_ONES32,
			5'd10);
		send_fields(mdhl_pkg::CMD_MADD, 1, mdhl_pkg::INT_MIN32, 32'h7FFF_FFFF, 5'd11);
		send_fields(mdhl_pkg::CMD_MADD, 1, mdhl_pkg::ALL_ONES32, 32'd1, 5'd0);
		send_fields(3'd6, 0, 32'd1, 32'd2, 5'd12);
		send_fields(3'd7, 1, mdhl_pkg::ALL_ONES32, mdhl_pkg::ALL_ONES32, 5'd31);

		// random, three idling regimes
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
			for (n = 0; n < 600; n++) begin
				if (phase == 2 && n == 100) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (300) @(negedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				send_fields(($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
					: 3'($urandom_range(5)), 1'($urandom), pick_operand(),
					pick_operand(), 5'($urandom));
			end
		end
		in_valid <= 1'b0;

		waited = 0;
		while (sb.pending_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/mdhl_pkg.sv
src/mdhl_front.sv
src/mdhl_back.sv
src/mult_div_hilo_unit.sv
dv/testbench.sv
